// ----- hw/rtl/kbd_pkg.sv -----
// Shared types, codes and scancode tables for the keyboard scancode decoder.
`default_nettype none

package kbd_pkg;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_CHAR    = 3'd1;
    localparam logic [2:0] KIND_NAV     = 3'd2;
    localparam logic [2:0] KIND_CONSOLE = 3'd3;
    localparam logic [2:0] KIND_ALT_TAB = 3'd4;
    localparam logic [2:0] KIND_INTR    = 3'd5;
    localparam logic [2:0] KIND_SCR_UP  = 3'd6;
    localparam logic [2:0] KIND_SCR_DN  = 3'd7;

    localparam logic [3:0] NAV_LEFT  = 4'd0;
    localparam logic [3:0] NAV_RIGHT = 4'd1;
    localparam logic [3:0] NAV_UP    = 4'd2;
    localparam logic [3:0] NAV_DOWN  = 4'd3;
    localparam logic [3:0] NAV_PGUP  = 4'd4;
    localparam logic [3:0] NAV_PGDN  = 4'd5;
    localparam logic [3:0] NAV_HOME  = 4'd6;
    localparam logic [3:0] NAV_END   = 4'd7;
    localparam logic [3:0] NAV_DEL   = 4'd8;

    localparam logic CFG_FOREGROUND_IS_SHELL = 1'b0;
    localparam logic CFG_IGNORE_PORT_INPUT   = 1'b1;

    localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
    localparam logic [7:0] SC_PREFIX_F0 = 8'hF0;
    localparam logic [7:0] SC_ACK       = 8'hFA;
    localparam logic [7:0] SC_RESEND    = 8'hFE;
    localparam logic [7:0] SC_ECHO      = 8'hEE;
    localparam logic [7:0] SC_LAST_MAP  = 8'h39;

    typedef struct packed {
        logic foreground_is_shell;
        logic ignore_port_input;
    } cfg_t;

    typedef struct packed {
        logic prefix_e0;
        logic prefix_f0;
        logic shift_held;
        logic ctrl_held;
        logic left_alt_held;
        logic caps_lock;
        logic num_lock;
        logic ime_mode;
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] key_code;
        logic [3:0] nav_key;
        logic [1:0] console_index;
        logic       alt_tab_reverse;
        logic       mod_shift;
        logic       mod_ctrl;
        logic       mod_alt;
        logic       caps_on;
        logic       num_on;
        logic       ime_on;
        logic       led_update;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } nav_t;

    function automatic nav_t nav_lookup(input logic [7:0] sc);
        nav_t n;
        n.hit  = 1'b1;
        n.code = NAV_LEFT;
        case (sc)
            8'h4B: n.code = NAV_LEFT;
            8'h4D: n.code = NAV_RIGHT;
            8'h48: n.code = NAV_UP;
            8'h50: n.code = NAV_DOWN;
            8'h49: n.code = NAV_PGUP;
            8'h51: n.code = NAV_PGDN;
            8'h47: n.code = NAV_HOME;
            8'h4F: n.code = NAV_END;
            8'h53: n.code = NAV_DEL;
            default: n.hit = 1'b0;
        endcase
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [7:0] base_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'h01: c = 8'd27;
            6'h02: c = "1";
            6'h03: c = "2";
            6'h04: c = "3";
            6'h05: c = "4";
            6'h06: c = "5";
            6'h07: c = "6";
            6'h08: c = "7";
            6'h09: c = "8";
            6'h0A: c = "9";
            6'h0B: c = "0";
            6'h0C: c = "-";
            6'h0D: c = "=";
            6'h0E: c = 8'd8;
            6'h0F: c = 8'd9;
            6'h10: c = "q";
            6'h11: c = "w";
            6'h12: c = "e";
            6'h13: c = "r";
            6'h14: c = "t";
            6'h15: c = "y";
            6'h16: c = "u";
            6'h17: c = "i";
            6'h18: c = "o";
            6'h19: c = "p";
            6'h1A: c = "[";
            6'h1B: c = "]";
            6'h1C: c = 8'd10;
            6'h1E: c = "a";
            6'h1F: c = "s";
            6'h20: c = "d";
            6'h21: c = "f";
            6'h22: c = "g";
            6'h23: c = "h";
            6'h24: c = "j";
            6'h25: c = "k";
            6'h26: c = "l";
            6'h27: c = ";";
            6'h28: c = 8'h27;
            6'h29: c = 8'h60;
            6'h2B: c = 8'h5C;
            6'h2C: c = "z";
            6'h2D: c = "x";
            6'h2E: c = "c";
            6'h2F: c = "v";
            6'h30: c = "b";
            6'h31: c = "n";
            6'h32: c = "m";
            6'h33: c = ",";
            6'h34: c = ".";
            6'h35: c = "/";
            6'h37: c = "*";
            6'h39: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] shift_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'h01: c = 8'd27;
            6'h02: c = "!";
            6'h03: c = "@";
            6'h04: c = "#";
            6'h05: c = "$";
            6'h06: c = "%";
            6'h07: c = "^";
            6'h08: c = "&";
            6'h09: c = "*";
            6'h0A: c = "(";
            6'h0B: c = ")";
            6'h0C: c = "_";
            6'h0D: c = "+";
            6'h0E: c = 8'd8;
            6'h0F: c = 8'd9;
            6'h1A: c = "{";
            6'h1B: c = "}";
            6'h1C: c = 8'd10;
            6'h27: c = ":";
            6'h28: c = 8'h22;
            6'h29: c = "~";
            6'h2B: c = "|";
            6'h33: c = "<";
            6'h34: c = ">";
            6'h35: c = "?";
            6'h37: c = "*";
            6'h39: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kbd_in_if.sv -----
// Scancode input channel: valid/ready handshake with scancode payload.
`default_nettype none

interface kbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;
    logic       from_port;

    modport source (output valid, output scancode, output from_port, input ready);
    modport sink (input valid, input scancode, input from_port, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kbd_out_if.sv -----
// Decoded event output channel: valid/ready handshake with event payload.
`default_nettype none

interface kbd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] key_code;
    logic [3:0] nav_key;
    logic [1:0] console_index;
    logic       alt_tab_reverse;
    logic       mod_shift;
    logic       mod_ctrl;
    logic       mod_alt;
    logic       caps_on;
    logic       num_on;
    logic       ime_on;
    logic       led_update;

    modport source (
        output valid, output kind, output key_code, output nav_key, output console_index,
        output alt_tab_reverse, output mod_shift, output mod_ctrl, output mod_alt,
        output caps_on, output num_on, output ime_on, output led_update,
        input ready
    );
    modport sink (
        input valid, input kind, input key_code, input nav_key, input console_index,
        input alt_tab_reverse, input mod_shift, input mod_ctrl, input mod_alt,
        input caps_on, input num_on, input ime_on, input led_update,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/kbd_decode.sv -----
// Combinational decode of one scancode byte against the current key state.
`default_nettype none

module kbd_decode (
    input  wire logic [7:0]    scancode,
    input  wire logic          from_port,
    input  wire kbd_pkg::cfg_t cfg,
    input  wire kbd_pkg::state_t state,
    output kbd_pkg::state_t    state_next,
    output kbd_pkg::res_t      res
);

    kbd_pkg::nav_t nav;
    logic [7:0]    keypad;
    logic [7:0]    map_char;
    logic [7:0]    base;
    logic [1:0]    con_diff;
    logic          put_en;
    logic [7:0]    put_c;
    logic          ime_shell;
    logic          qwertop;

    assign nav       = kbd_pkg::nav_lookup(scancode);
    assign ime_shell = state.ime_mode && cfg.foreground_is_shell;
    assign con_diff  = scancode[1:0] - 2'b11;
    assign base      = kbd_pkg::base_char(scancode[5:0]);
    assign qwertop   = (base == "q") || (base == "w") || (base == "e") || (base == "r") ||
                       (base == "t") || (base == "o") || (base == "p");

    always_comb
    begin
        keypad = 8'h00;
        case (scancode)
            8'h37: keypad = "*";
            8'h4A: keypad = "-";
            8'h4E: keypad = "+";
            8'h52: keypad = state.num_lock ? "0" : 8'h00;
            8'h53: keypad = state.num_lock ? "." : 8'h00;
            8'h4F: keypad = state.num_lock ? "1" : 8'h00;
            8'h50: keypad = state.num_lock ? "2" : 8'h00;
            8'h51: keypad = state.num_lock ? "3" : 8'h00;
            8'h4B: keypad = state.num_lock ? "4" : 8'h00;
            8'h4C: keypad = state.num_lock ? "5" : 8'h00;
            8'h4D: keypad = state.num_lock ? "6" : 8'h00;
            8'h47: keypad = state.num_lock ? "7" : 8'h00;
            8'h48: keypad = state.num_lock ? "8" : 8'h00;
            8'h49: keypad = state.num_lock ? "9" : 8'h00;
            default: keypad = 8'h00;
        endcase
    end

    always_comb
    begin
        if (state.left_alt_held)
        begin
            map_char = scancode - 8'd1;
        end
        else if ((base >= "a") && (base <= "z"))
        begin
            if (ime_shell)
            begin
                map_char = (state.shift_held && qwertop) ? (base - 8'h20) : base;
            end
            else
            begin
                map_char = (state.shift_held ^ state.caps_lock) ? (base - 8'h20) : base;
            end
        end
        else if (state.shift_held)
        begin
            map_char = kbd_pkg::shift_char(scancode[5:0]);
        end
        else
        begin
            map_char = base;
        end
    end

    always_comb
    begin
        state_next = state;
        res        = '0;
        put_en     = 1'b0;
        put_c      = 8'h00;

        if (from_port && ((scancode == kbd_pkg::SC_ACK) || (scancode == kbd_pkg::SC_RESEND) ||
                          (scancode == kbd_pkg::SC_ECHO)))
        begin
            state_next = state;
        end
        else if (from_port && cfg.ignore_port_input)
        begin
            state_next = state;
        end
        else if (scancode == kbd_pkg::SC_PREFIX_E0)
        begin
            state_next.prefix_e0 = 1'b1;
        end
        else if (scancode == kbd_pkg::SC_PREFIX_F0)
        begin
            state_next.prefix_f0 = 1'b1;
        end
        else if (state.prefix_f0)
        begin
            if (state.prefix_e0)
            begin
                if (scancode == 8'h14)
                begin
                    state_next.ctrl_held = 1'b0;
                end
                state_next.prefix_e0 = 1'b0;
            end
            else if ((scancode == 8'h12) || (scancode == 8'h59))
            begin
                state_next.shift_held = 1'b0;
            end
            else if (scancode == 8'h11)
            begin
                state_next.left_alt_held = 1'b0;
            end
            else if (scancode == 8'h14)
            begin
                state_next.ctrl_held = 1'b0;
            end
            state_next.prefix_f0 = 1'b0;
        end
        else if (scancode[7])
        begin
            if (state.prefix_e0)
            begin
                state_next.prefix_e0 = 1'b0;
            end
            else
            begin
                if (scancode == 8'h9D)
                begin
                    state_next.ctrl_held = 1'b0;
                end
                if (scancode == 8'hB8)
                begin
                    state_next.left_alt_held = 1'b0;
                end
                if ((scancode == 8'hAA) || (scancode == 8'hB6))
                begin
                    state_next.shift_held = 1'b0;
                end
            end
        end
        else if (scancode == 8'h38)
        begin
            if (state.prefix_e0)
            begin
                state_next.ime_mode  = ~state.ime_mode;
                state_next.prefix_e0 = 1'b0;
            end
            else
            begin
                state_next.left_alt_held = 1'b1;
            end
        end
        else if (state.left_alt_held && (scancode >= 8'h3B) && (scancode <= 8'h3E))
        begin
            res.kind                 = kbd_pkg::KIND_CONSOLE;
            res.console_index        = con_diff;
            state_next.shift_held    = 1'b0;
            state_next.left_alt_held = 1'b0;
            state_next.prefix_e0     = 1'b0;
            state_next.prefix_f0     = 1'b0;
        end
        else if ((scancode == 8'h2A) || (scancode == 8'h36))
        begin
            state_next.shift_held = 1'b1;
        end
        else if (scancode == 8'h3A)
        begin
            state_next.caps_lock = ~state.caps_lock;
            res.led_update       = 1'b1;
        end
        else if (scancode == 8'h45)
        begin
            state_next.num_lock = ~state.num_lock;
            res.led_update      = 1'b1;
        end
        else if (scancode == 8'h1D)
        begin
            state_next.ctrl_held = 1'b1;
        end
        else if ((scancode == 8'h0F) && state.left_alt_held)
        begin
            res.kind            = kbd_pkg::KIND_ALT_TAB;
            res.alt_tab_reverse = state.shift_held;
        end
        else if (state.ctrl_held && (scancode == 8'h12))
        begin
            res.kind                 = kbd_pkg::KIND_INTR;
            state_next.ctrl_held     = 1'b0;
            state_next.shift_held    = 1'b0;
            state_next.left_alt_held = 1'b0;
            state_next.prefix_e0     = 1'b0;
            state_next.prefix_f0     = 1'b0;
        end
        else if (state.prefix_e0)
        begin
            state_next.prefix_e0 = 1'b0;
            if (scancode == 8'h1C)
            begin
                res.kind     = kbd_pkg::KIND_CHAR;
                res.key_code = 8'd10;
            end
            else if (scancode == 8'h35)
            begin
                put_en = 1'b1;
                put_c  = "/";
            end
            else if (nav.hit)
            begin
                res.kind                 = kbd_pkg::KIND_NAV;
                res.nav_key              = nav.code;
                state_next.shift_held    = 1'b0;
                state_next.left_alt_held = 1'b0;
                state_next.prefix_f0     = 1'b0;
            end
        end
        else if (scancode == 8'h0E)
        begin
            res.kind     = kbd_pkg::KIND_CHAR;
            res.key_code = 8'd8;
        end
        else if (scancode == 8'h1C)
        begin
            res.kind     = kbd_pkg::KIND_CHAR;
            res.key_code = 8'd10;
        end
        else if (scancode == 8'h01)
        begin
            res.kind                 = kbd_pkg::KIND_CHAR;
            res.key_code             = 8'd27;
            state_next.shift_held    = 1'b0;
            state_next.left_alt_held = 1'b0;
            state_next.prefix_f0     = 1'b0;
        end
        else if (keypad != 8'h00)
        begin
            put_en = 1'b1;
            put_c  = keypad;
        end
        else if (!state.num_lock && ((scancode == 8'h4B) || (scancode == 8'h4D) ||
                                     (scancode == 8'h48) || (scancode == 8'h50)))
        begin
            res.kind                 = kbd_pkg::KIND_NAV;
            res.nav_key              = nav.code;
            state_next.shift_held    = 1'b0;
            state_next.left_alt_held = 1'b0;
            state_next.prefix_f0     = 1'b0;
        end
        else if (!state.num_lock && ((scancode == 8'h49) || (scancode == 8'h51)))
        begin
            if (cfg.foreground_is_shell)
            begin
                res.kind = (scancode == 8'h49) ? kbd_pkg::KIND_SCR_UP : kbd_pkg::KIND_SCR_DN;
            end
            else
            begin
                res.kind    = kbd_pkg::KIND_NAV;
                res.nav_key = nav.code;
            end
            state_next.shift_held    = 1'b0;
            state_next.left_alt_held = 1'b0;
            state_next.prefix_f0     = 1'b0;
        end
        else if (scancode <= kbd_pkg::SC_LAST_MAP)
        begin
            put_en = 1'b1;
            put_c  = map_char;
        end

        if (put_en && (put_c != 8'h00))
        begin
            res.kind = kbd_pkg::KIND_CHAR;
            if (state.ctrl_held && kbd_pkg::is_alpha(put_c))
            begin
                res.key_code             = {state.shift_held, 1'b0, state.shift_held, put_c[4:0]};
                state_next.shift_held    = 1'b0;
                state_next.left_alt_held = 1'b0;
                state_next.prefix_e0     = 1'b0;
                state_next.prefix_f0     = 1'b0;
            end
            else
            begin
                res.key_code = put_c;
            end
            if (ime_shell && kbd_pkg::is_alpha(put_c))
            begin
                state_next.shift_held = 1'b0;
            end
        end

        if ((res.kind == kbd_pkg::KIND_CHAR) || (res.kind == kbd_pkg::KIND_NAV))
        begin
            res.mod_shift = state.shift_held;
            res.mod_ctrl  = state.ctrl_held;
            res.mod_alt   = state.left_alt_held;
            res.caps_on   = state.caps_lock;
            res.num_on    = state.num_lock;
            res.ime_on    = state.ime_mode;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/keyboard_scancode_decoder.sv -----
// Keyboard scancode decoder top level: input register, decode, result register.
// A scancode loads the input register; its decode loads result and key state.
// Throughput: one scancode per cycle unless the result receiver stalls.
// Either register stage takes a new transfer while its content moves on.
// Reset clears all key state, both prefixes and both configuration bits.
`default_nettype none

module keyboard_scancode_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kbd_in_if.sink     scan,
    kbd_out_if.source  result,
    input  wire logic  cfg_write,
    input  wire logic  cfg_index,
    input  wire logic  cfg_data
);

    logic            in_valid_reg;
    logic [7:0]      sc_reg;
    logic            port_reg;
    logic            out_valid_reg;
    kbd_pkg::res_t   res_reg;
    kbd_pkg::res_t   res;
    kbd_pkg::state_t state_reg;
    kbd_pkg::state_t state_next;
    kbd_pkg::cfg_t   cfg_reg;
    logic            advance;
    logic            take;

    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign scan.ready = !in_valid_reg || advance;
    assign take      = scan.valid && scan.ready;

    kbd_decode u_decode (
        .scancode   (sc_reg),
        .from_port  (port_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                kbd_pkg::CFG_FOREGROUND_IS_SHELL: cfg_reg.foreground_is_shell <= cfg_data;
                kbd_pkg::CFG_IGNORE_PORT_INPUT:   cfg_reg.ignore_port_input   <= cfg_data;
                default:                          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sc_reg   <= scan.scancode;
            port_reg <= scan.from_port;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.kind            = res_reg.kind;
    assign result.key_code        = res_reg.key_code;
    assign result.nav_key         = res_reg.nav_key;
    assign result.console_index   = res_reg.console_index;
    assign result.alt_tab_reverse = res_reg.alt_tab_reverse;
    assign result.mod_shift       = res_reg.mod_shift;
    assign result.mod_ctrl        = res_reg.mod_ctrl;
    assign result.mod_alt         = res_reg.mod_alt;
    assign result.caps_on         = res_reg.caps_on;
    assign result.num_on          = res_reg.num_on;
    assign result.ime_on          = res_reg.ime_on;
    assign result.led_update      = res_reg.led_update;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the keyboard scancode decoder: directed and random scancode streams.
`timescale 1ns / 100ps

module tb;

    localparam logic [7:0] SC_ESC      = 8'h01;
    localparam logic [7:0] SC_TAB      = 8'h0F;
    localparam logic [7:0] SC_Q        = 8'h10;
    localparam logic [7:0] SC_INTR_KEY = 8'h12;
    localparam logic [7:0] SC_ENTER    = 8'h1C;
    localparam logic [7:0] SC_CTRL     = 8'h1D;
    localparam logic [7:0] SC_A        = 8'h1E;
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_C        = 8'h2E;
    localparam logic [7:0] SC_SLASH    = 8'h35;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_ALT      = 8'h38;
    localparam logic [7:0] SC_CAPS     = 8'h3A;
    localparam logic [7:0] SC_F1       = 8'h3B;
    localparam logic [7:0] SC_F2       = 8'h3C;
    localparam logic [7:0] SC_F4       = 8'h3E;
    localparam logic [7:0] SC_NUM      = 8'h45;
    localparam logic [7:0] SC_KP_UP    = 8'h48;
    localparam logic [7:0] SC_KP_PGUP  = 8'h49;
    localparam logic [7:0] SC_KP_LEFT  = 8'h4B;
    localparam logic [7:0] SC_KP_RIGHT = 8'h4D;
    localparam logic [7:0] SC_KP_END   = 8'h4F;
    localparam logic [7:0] SC_KP_DOWN  = 8'h50;
    localparam logic [7:0] SC_KP_PGDN  = 8'h51;
    localparam logic [7:0] SC_BKSP     = 8'h0E;
    localparam logic [7:0] SC_RANDOM_TOP = 8'h58;

    localparam logic [7:0] BRK_CTRL   = 8'h9D;
    localparam logic [7:0] BRK_ALT    = 8'hB8;
    localparam logic [7:0] BRK_LSHIFT = 8'hAA;
    localparam logic [7:0] BRK_RSHIFT = 8'hB6;

    localparam logic [7:0] REL_LSHIFT = 8'h12;
    localparam logic [7:0] REL_RSHIFT = 8'h59;
    localparam logic [7:0] REL_ALT    = 8'h11;
    localparam logic [7:0] REL_CTRL   = 8'h14;

    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CTRL_SHIFT_MARK = 8'hA0;

    localparam logic [8*58-1:0] BASE_ROW = {
        8'h00, CH_ESC, "1234567890-=", CH_BS, CH_TAB, "qwertyuiop[]", CH_LF, 8'h00,
        "asdfghjkl;", 8'h27, 8'h60, 8'h00, 8'h5C, "zxcvbnm,./", 8'h00, "*", 8'h00, " "
    };
    localparam logic [8*58-1:0] SHIFT_ROW = {
        8'h00, CH_ESC, "!@#$%^&*()_+", CH_BS, CH_TAB, 80'h0, "{}", CH_LF, 8'h00,
        72'h0, ":", 8'h22, "~", 8'h00, "|", 56'h0, "<>?", 8'h00, "*", 8'h00, " "
    };

    localparam logic [8*6-1:0] MOD_MAKES = {SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT, SC_CAPS,
                                            SC_NUM};
    localparam logic [8*4-1:0] MOD_BREAKS = {BRK_CTRL, BRK_ALT, BRK_LSHIFT, BRK_RSHIFT};
    localparam logic [8*4-1:0] MOD_RELEASES = {REL_LSHIFT, REL_RSHIFT, REL_ALT, REL_CTRL};
    localparam logic [8*3-1:0] REPLY_CODES = {kbd_pkg::SC_ACK, kbd_pkg::SC_RESEND,
                                              kbd_pkg::SC_ECHO};
    localparam logic [8*11-1:0] EXT_CODES = {SC_ENTER, SC_SLASH, SC_KP_LEFT, SC_KP_RIGHT,
                                             SC_KP_UP, SC_KP_DOWN, SC_KP_PGUP, SC_KP_PGDN,
                                             8'h47, SC_KP_END, 8'h53};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic cfg_data;

    kbd_in_if scan ();
    kbd_out_if result ();

    keyboard_scancode_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .scan(scan),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    kbd_pkg::cfg_t   mode;
    kbd_pkg::state_t keys;
    kbd_pkg::res_t   pending_key_events[$];
    kbd_pkg::res_t   oldest_event;
    kbd_pkg::res_t   actual_event;
    int     errors = 0;
    int     idle_pct;
    int     stall_pct;
    int     sent;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] map_char(input logic shifted, input logic [7:0] sc);
        int idx;
        idx = 57 - int'(sc);
        return shifted ? SHIFT_ROW[8*idx +: 8] : BASE_ROW[8*idx +: 8];
    endfunction

    function automatic int nav_index(input logic [7:0] sc);
        case (sc)
            SC_KP_LEFT:  return int'(kbd_pkg::NAV_LEFT);
            SC_KP_RIGHT: return int'(kbd_pkg::NAV_RIGHT);
            SC_KP_UP:    return int'(kbd_pkg::NAV_UP);
            SC_KP_DOWN:  return int'(kbd_pkg::NAV_DOWN);
            SC_KP_PGUP:  return int'(kbd_pkg::NAV_PGUP);
            SC_KP_PGDN:  return int'(kbd_pkg::NAV_PGDN);
            8'h47:       return int'(kbd_pkg::NAV_HOME);
            SC_KP_END:   return int'(kbd_pkg::NAV_END);
            8'h53:       return int'(kbd_pkg::NAV_DEL);
            default:     return -1;
        endcase
    endfunction

    function automatic logic [7:0] keypad_char(input logic [7:0] sc);
        logic [7:0] c;
        case (sc)
            8'h37:   c = "*";
            8'h4A:   c = "-";
            8'h4E:   c = "+";
            default: c = 8'h00;
        endcase
        if (c == 8'h00 && keys.num_lock)
        begin
            case (sc)
                8'h52: c = "0";
                8'h53: c = ".";
                8'h4F: c = "1";
                8'h50: c = "2";
                8'h51: c = "3";
                8'h4B: c = "4";
                8'h4C: c = "5";
                8'h4D: c = "6";
                8'h47: c = "7";
                8'h48: c = "8";
                8'h49: c = "9";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic void drop_mods();
        keys.shift_held = 1'b0;
        keys.left_alt_held = 1'b0;
        keys.prefix_e0 = 1'b0;
        keys.prefix_f0 = 1'b0;
    endfunction

    function automatic kbd_pkg::res_t with_mods(input kbd_pkg::res_t ev);
        ev.mod_shift = keys.shift_held;
        ev.mod_ctrl = keys.ctrl_held;
        ev.mod_alt = keys.left_alt_held;
        ev.caps_on = keys.caps_lock;
        ev.num_on = keys.num_lock;
        ev.ime_on = keys.ime_mode;
        return ev;
    endfunction

    function automatic kbd_pkg::res_t char_event(input logic [7:0] c);
        kbd_pkg::res_t ev;
        ev = '0;
        ev.kind = kbd_pkg::KIND_CHAR;
        ev.key_code = c;
        return with_mods(ev);
    endfunction

    function automatic kbd_pkg::res_t nav_event(input int n);
        kbd_pkg::res_t ev;
        ev = '0;
        ev.kind = kbd_pkg::KIND_NAV;
        ev.nav_key = n[3:0];
        ev = with_mods(ev);
        drop_mods();
        return ev;
    endfunction

    function automatic kbd_pkg::res_t typed_event(input logic [7:0] c);
        kbd_pkg::res_t ev;
        logic ime_key;
        ev = '0;
        ime_key = keys.ime_mode && mode.foreground_is_shell && is_letter(c);
        if (c == 8'h00)
            return ev;
        if (keys.ctrl_held && is_letter(c))
        begin
            ev = char_event((c & 8'h1F) | (keys.shift_held ? CTRL_SHIFT_MARK : 8'h00));
            drop_mods();
        end
        else
            ev = char_event(c);
        if (ime_key)
            keys.shift_held = 1'b0;
        return ev;
    endfunction

    function automatic kbd_pkg::res_t decode_key_event(input logic [7:0] sc, input logic port);
        kbd_pkg::res_t ev;
        logic [7:0] c;
        ev = '0;
        if (port && (sc == kbd_pkg::SC_ACK || sc == kbd_pkg::SC_RESEND ||
                     sc == kbd_pkg::SC_ECHO))
            return ev;
        if (port && mode.ignore_port_input)
            return ev;
        if (sc == kbd_pkg::SC_PREFIX_E0)
        begin
            keys.prefix_e0 = 1'b1;
            return ev;
        end
        if (sc == kbd_pkg::SC_PREFIX_F0)
        begin
            keys.prefix_f0 = 1'b1;
            return ev;
        end
        if (keys.prefix_f0)
        begin
            if (keys.prefix_e0)
            begin
                if (sc == REL_CTRL)
                    keys.ctrl_held = 1'b0;
                keys.prefix_e0 = 1'b0;
            end
            else if (sc == REL_LSHIFT || sc == REL_RSHIFT)
                keys.shift_held = 1'b0;
            else if (sc == REL_ALT)
                keys.left_alt_held = 1'b0;
            else if (sc == REL_CTRL)
                keys.ctrl_held = 1'b0;
            keys.prefix_f0 = 1'b0;
            return ev;
        end
        if (sc[7])
        begin
            if (keys.prefix_e0)
            begin
                keys.prefix_e0 = 1'b0;
                return ev;
            end
            if (sc == BRK_CTRL)
                keys.ctrl_held = 1'b0;
            if (sc == BRK_ALT)
                keys.left_alt_held = 1'b0;
            if (sc == BRK_LSHIFT || sc == BRK_RSHIFT)
                keys.shift_held = 1'b0;
            return ev;
        end
        if (sc == SC_ALT)
        begin
            if (keys.prefix_e0)
            begin
                keys.ime_mode = !keys.ime_mode;
                keys.prefix_e0 = 1'b0;
            end
            else
                keys.left_alt_held = 1'b1;
            return ev;
        end
        if (keys.left_alt_held && sc >= SC_F1 && sc <= SC_F4)
        begin
            ev.kind = kbd_pkg::KIND_CONSOLE;
            ev.console_index = sc[1:0] - SC_F1[1:0];
            drop_mods();
            return ev;
        end
        if (sc == SC_LSHIFT || sc == SC_RSHIFT)
        begin
            keys.shift_held = 1'b1;
            return ev;
        end
        if (sc == SC_CAPS)
        begin
            keys.caps_lock = !keys.caps_lock;
            ev.led_update = 1'b1;
            return ev;
        end
        if (sc == SC_NUM)
        begin
            keys.num_lock = !keys.num_lock;
            ev.led_update = 1'b1;
            return ev;
        end
        if (sc == SC_CTRL)
        begin
            keys.ctrl_held = 1'b1;
            return ev;
        end
        if (sc == SC_TAB && keys.left_alt_held)
        begin
            ev.kind = kbd_pkg::KIND_ALT_TAB;
            ev.alt_tab_reverse = keys.shift_held;
            return ev;
        end
        if (keys.ctrl_held && sc == SC_INTR_KEY)
        begin
            ev.kind = kbd_pkg::KIND_INTR;
            keys.ctrl_held = 1'b0;
            drop_mods();
            return ev;
        end
        if (keys.prefix_e0)
        begin
            keys.prefix_e0 = 1'b0;
            if (sc == SC_ENTER)
                return char_event(CH_LF);
            if (sc == SC_SLASH)
                return typed_event("/");
            if (nav_index(sc) >= 0)
                return nav_event(nav_index(sc));
            return ev;
        end
        if (sc == SC_BKSP)
            return char_event(CH_BS);
        if (sc == SC_ENTER)
            return char_event(CH_LF);
        if (sc == SC_ESC)
        begin
            ev = char_event(CH_ESC);
            drop_mods();
            return ev;
        end
        c = keypad_char(sc);
        if (c != 8'h00)
            return typed_event(c);
        if (!keys.num_lock)
        begin
            if (sc == SC_KP_LEFT || sc == SC_KP_RIGHT || sc == SC_KP_UP || sc == SC_KP_DOWN)
                return nav_event(nav_index(sc));
            if (sc == SC_KP_PGUP || sc == SC_KP_PGDN)
            begin
                if (!mode.foreground_is_shell)
                    return nav_event(nav_index(sc));
                ev.kind = (sc == SC_KP_PGUP) ? kbd_pkg::KIND_SCR_UP : kbd_pkg::KIND_SCR_DN;
                drop_mods();
                return ev;
            end
        end
        if (sc > kbd_pkg::SC_LAST_MAP)
            return ev;
        if (keys.left_alt_held)
            c = sc - 8'd1;
        else
        begin
            c = map_char(1'b0, sc);
            if (c >= "a" && c <= "z")
            begin
                if (keys.ime_mode && mode.foreground_is_shell)
                begin
                    if (keys.shift_held && (c == "q" || c == "w" || c == "e" || c == "r" ||
                                            c == "t" || c == "o" || c == "p"))
                        c = c - 8'h20;
                end
                else if (keys.shift_held ^ keys.caps_lock)
                    c = c - 8'h20;
            end
            else if (keys.shift_held)
                c = map_char(1'b1, sc);
        end
        return typed_event(c);
    endfunction

    task automatic send_scancode(input logic [7:0] sc, input logic port);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            scan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan.valid <= 1'b1;
        scan.scancode <= sc;
        scan.from_port <= port;
        do
            @(posedge clk);
        while (!scan.ready);
        pending_key_events.push_back(decode_key_event(sc, port));
        sent++;
    endtask

    task automatic wait_drained();
        scan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_key_events.size() != 0);
    endtask

    task automatic write_register(input logic idx, input logic value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == kbd_pkg::CFG_FOREGROUND_IS_SHELL)
            mode.foreground_is_shell = value;
        else
            mode.ignore_port_input = value;
    endtask

    function automatic logic random_port();
        return $urandom_range(3) == 0;
    endfunction

    task automatic send_random_keystroke();
        logic [7:0] sc;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7:
            begin
                sc = 8'($urandom_range(SC_RANDOM_TOP));
                send_scancode(sc, random_port());
            end
            8, 9:
            begin
                sc = MOD_MAKES[8*$urandom_range(5) +: 8];
                send_scancode(sc, random_port());
            end
            10:
            begin
                send_scancode(kbd_pkg::SC_PREFIX_E0, random_port());
                send_scancode($urandom_range(1) ? SC_ALT : SC_CTRL, random_port());
            end
            11, 12:
            begin
                sc = MOD_BREAKS[8*$urandom_range(3) +: 8];
                if ($urandom_range(3) == 0)
                begin
                    sc = 8'($urandom);
                    sc[7] = 1'b1;
                end
                send_scancode(sc, random_port());
            end
            13:
            begin
                sc = MOD_RELEASES[8*$urandom_range(3) +: 8];
                if ($urandom_range(3) == 0)
                    sc = 8'($urandom);
                send_scancode(kbd_pkg::SC_PREFIX_F0, random_port());
                send_scancode(sc, random_port());
            end
            14:
            begin
                send_scancode(kbd_pkg::SC_PREFIX_E0, random_port());
                if ($urandom_range(1))
                begin
                    send_scancode(kbd_pkg::SC_PREFIX_F0, random_port());
                    send_scancode(REL_CTRL, random_port());
                end
                else
                begin
                    sc = 8'($urandom);
                    sc[7] = 1'b1;
                    send_scancode(sc, random_port());
                end
            end
            15, 16:
            begin
                sc = EXT_CODES[8*$urandom_range(10) +: 8];
                if ($urandom_range(3) == 0)
                    sc = 8'($urandom);
                send_scancode(kbd_pkg::SC_PREFIX_E0, random_port());
                send_scancode(sc, random_port());
            end
            17:
            begin
                sc = $urandom_range(1) ? SC_TAB : 8'(SC_F1 + $urandom_range(3));
                send_scancode(SC_ALT, random_port());
                send_scancode(sc, random_port());
            end
            18:
            begin
                sc = REPLY_CODES[8*$urandom_range(2) +: 8];
                send_scancode(sc, 1'b1);
            end
            default:
            begin
                sc = 8'($urandom);
                send_scancode(sc, 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic test_directed_keys();
        send_scancode(8'h00, 1'b0);
        send_scancode(8'hFF, 1'b0);
        send_scancode(kbd_pkg::SC_ACK, 1'b1);
        send_scancode(kbd_pkg::SC_RESEND, 1'b1);
        send_scancode(kbd_pkg::SC_ECHO, 1'b1);
        send_scancode(kbd_pkg::SC_ACK, 1'b0);
        send_scancode(SC_LSHIFT, 1'b0);
        send_scancode(SC_A, 1'b0);
        send_scancode(SC_CAPS, 1'b0);
        send_scancode(SC_NUM, 1'b0);
        send_scancode(SC_KP_END, 1'b0);
        send_scancode(kbd_pkg::SC_PREFIX_E0, 1'b0);
        send_scancode(SC_KP_LEFT, 1'b0);
        send_scancode(SC_CTRL, 1'b0);
        send_scancode(SC_INTR_KEY, 1'b0);
        send_scancode(SC_ALT, 1'b0);
        send_scancode(SC_F2, 1'b0);
        send_scancode(SC_ALT, 1'b0);
        send_scancode(SC_TAB, 1'b0);
        send_scancode(8'h02, 1'b0);
        send_scancode(8'h00, 1'b0);
        send_scancode(BRK_ALT, 1'b0);
        send_scancode(kbd_pkg::SC_PREFIX_E0, 1'b0);
        send_scancode(SC_ALT, 1'b0);
        send_scancode(SC_ESC, 1'b0);
        send_scancode(SC_CTRL, 1'b0);
        send_scancode(SC_RSHIFT, 1'b0);
        send_scancode(SC_C, 1'b0);
        send_scancode(kbd_pkg::SC_PREFIX_F0, 1'b0);
        send_scancode(REL_CTRL, 1'b0);
    endtask

    task automatic test_shell_keys();
        write_register(kbd_pkg::CFG_FOREGROUND_IS_SHELL, 1'b1);
        write_register(kbd_pkg::CFG_IGNORE_PORT_INPUT, 1'b1);
        send_scancode(SC_A, 1'b1);
        send_scancode(SC_LSHIFT, 1'b0);
        send_scancode(SC_Q, 1'b0);
        send_scancode(SC_A, 1'b0);
        send_scancode(SC_NUM, 1'b0);
        send_scancode(SC_KP_PGUP, 1'b0);
    endtask

    task automatic test_random_typing(input int sender_idle, input int receiver_stall,
                                      input logic shell, input logic drop_port,
                                      input int items);
        int target;
        target = sent + items;
        write_register(kbd_pkg::CFG_FOREGROUND_IS_SHELL, shell);
        write_register(kbd_pkg::CFG_IGNORE_PORT_INPUT, drop_port);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        while (sent < target)
        begin
            if ($urandom_range(59) == 0)
                wait_drained();
            send_random_keystroke();
        end
    endtask

    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            actual_event = {result.kind, result.key_code, result.nav_key, result.console_index,
                            result.alt_tab_reverse, result.mod_shift, result.mod_ctrl,
                            result.mod_alt, result.caps_on, result.num_on, result.ime_on,
                            result.led_update};
            if (pending_key_events.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none actual %h",
                         $time, actual_event);
                errors++;
            end
            else
            begin
                oldest_event = pending_key_events.pop_front();
                if (actual_event != oldest_event)
                begin
                    $display("%0t: result expected %h actual %h",
                             $time, oldest_event, actual_event);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        scan.valid = 1'b0;
        scan.scancode = 8'h00;
        scan.from_port = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        mode = '0;
        keys = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_keys();
        test_shell_keys();
        test_random_typing(0, 0, 1'b0, 1'b0, 300);
        test_random_typing(73, 0, 1'b1, 1'b0, 300);
        test_random_typing(0, 73, 1'b0, 1'b1, 300);
        test_random_typing(31, 31, 1'b1, 1'b1, 300);
        idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
